// ===== hdl/vrps_pkg.sv =====
// ----------------------------------------------------------------------------
// vrps_pkg
// Shared types and constants for the ray pick selector: item structs,
// register indexes, pick mode codes and table geometry.
// ----------------------------------------------------------------------------
package vrps_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
  localparam int SCALAR_BITS  = 16;
  localparam int SAMPLE_BITS  = 12;
  localparam int OPACITY_BITS = 8;
  localparam int ALPHA_BITS   = 16;
  localparam int METRIC_BITS  = 17;
  localparam int SCALE_BITS   = 24;
  localparam int SCALE_FRAC   = 16;
  localparam int MODE_BITS    = 2;
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 24;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_PICK_MODE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCALAR_MIN  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_INDEX_SCALE = 2'd2;

  // pick modes
  localparam logic [MODE_BITS-1:0] MODE_MAX_INTENSITY = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FIRST_HIT     = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_MAX_OPACITY   = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_MOST_CONTRIB  = 2'd3;

  // request types
  localparam logic REQ_TABLE_WRITE = 1'b0;
  localparam logic REQ_SAMPLE      = 1'b1;

  localparam logic [SCALE_BITS-1:0] INDEX_SCALE_RESET = 24'd256;

  typedef struct packed {
    logic                    req_type;
    logic [TABLE_AW-1:0]     table_addr;
    logic [OPACITY_BITS-1:0] opacity_byte;
    logic [SCALAR_BITS-1:0]  scalar;
    logic [SAMPLE_BITS-1:0]  sample_index;
    logic                    last_sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] picked_index;
    logic                   hit_found;
  } out_item_t;

endpackage

// ===== hdl/volume_ray_pick_selector.sv =====
// ----------------------------------------------------------------------------
// volume_ray_pick_selector
// Table write items do not hold the input side; ray sample items first read
// the opacity table into a register, then do alpha multiply and best update.
// A last sample's result goes to the output register from the pick state,
// later while an earlier result still waits; the input stalls during that wait.
// Reset clears per-ray state and registers; the opacity table is not cleared.
// ----------------------------------------------------------------------------
module volume_ray_pick_selector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vrps_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vrps_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [vrps_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [vrps_pkg::CFG_DW-1:0]         cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_PICK} state_t;

  localparam int PROD_W = vrps_pkg::SCALAR_BITS + vrps_pkg::SCALE_BITS;
  localparam int AMUL_W = vrps_pkg::ALPHA_BITS + vrps_pkg::ALPHA_BITS + 1;

  state_t state_r, state_nxt;

  logic [vrps_pkg::MODE_BITS-1:0]    pick_mode_r, pick_mode_nxt;
  logic [vrps_pkg::SCALAR_BITS-1:0]  scalar_min_r, scalar_min_nxt;
  logic [vrps_pkg::SCALE_BITS-1:0]   index_scale_r, index_scale_nxt;

  logic [vrps_pkg::METRIC_BITS-1:0]  best_metric_r, best_metric_nxt;
  logic [vrps_pkg::SAMPLE_BITS-1:0]  best_index_r, best_index_nxt;
  logic                              have_best_r, have_best_nxt;
  logic                              first_hit_done_r, first_hit_done_nxt;
  logic [vrps_pkg::ALPHA_BITS-1:0]   acc_alpha_r, acc_alpha_nxt;

  logic                              out_valid_r, out_valid_nxt;
  vrps_pkg::out_item_t               out_data_r, out_data_nxt;

  vrps_pkg::in_item_t                item_r;

  logic [vrps_pkg::OPACITY_BITS-1:0] opacity_mem [vrps_pkg::TABLE_DEPTH];
  logic [vrps_pkg::OPACITY_BITS-1:0] rdata_r;

  logic                              accept;
  logic                              tbl_we;
  logic                              tbl_re;
  logic [vrps_pkg::SCALAR_BITS-1:0]  diff;
  logic [PROD_W-1:0]                 prod;
  logic [vrps_pkg::TABLE_AW-1:0]     tbl_raddr;

  logic [vrps_pkg::ALPHA_BITS-1:0]   alpha_a;
  logic [vrps_pkg::ALPHA_BITS:0]     one_minus;
  logic [AMUL_W-1:0]                 amul;
  logic [vrps_pkg::METRIC_BITS-1:0]  inc;
  logic                              take;
  logic [vrps_pkg::METRIC_BITS-1:0]  metric;
  logic                              out_free;
  logic                              pick_go;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign tbl_we    = accept && (in_data.req_type == vrps_pkg::REQ_TABLE_WRITE);
  assign tbl_re    = accept && (in_data.req_type == vrps_pkg::REQ_SAMPLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // table index from the incoming scalar, saturated to the table end
  always_comb begin
    diff = (in_data.scalar > scalar_min_r) ? (in_data.scalar - scalar_min_r) : '0;
    prod = PROD_W'(diff) * PROD_W'(index_scale_r);
    if (|prod[PROD_W-1:vrps_pkg::SCALE_FRAC+vrps_pkg::TABLE_AW]) begin
      tbl_raddr = '1;
    end else begin
      tbl_raddr = prod[vrps_pkg::SCALE_FRAC +: vrps_pkg::TABLE_AW];
    end
  end

  // opacity table: one write or one read per cycle while the input is ready, read data registered
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      opacity_mem[in_data.table_addr] <= in_data.opacity_byte;
    end
    if (tbl_re) begin
      rdata_r <= opacity_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  // front-to-back alpha increment: byte * 257 is the Q0.16 alpha
  always_comb begin
    alpha_a   = {rdata_r, rdata_r};
    one_minus = {1'b1, {vrps_pkg::ALPHA_BITS{1'b0}}} - {1'b0, acc_alpha_r};
    amul      = AMUL_W'(alpha_a) * AMUL_W'(one_minus);
    inc       = amul[AMUL_W-1:vrps_pkg::ALPHA_BITS];
  end

  always_comb begin
    out_free = !out_valid_r || out_ready;
    pick_go  = (state_r == ST_PICK) && (!item_r.last_sample || out_free);

    state_nxt          = state_r;
    pick_mode_nxt      = pick_mode_r;
    scalar_min_nxt     = scalar_min_r;
    index_scale_nxt    = index_scale_r;
    best_metric_nxt    = best_metric_r;
    best_index_nxt     = best_index_r;
    have_best_nxt      = have_best_r;
    first_hit_done_nxt = first_hit_done_r;
    acc_alpha_nxt      = acc_alpha_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_data_nxt       = out_data_r;
    take               = 1'b0;
    metric             = '0;

    if (cfg_we) begin
      case (cfg_addr)
        vrps_pkg::REG_PICK_MODE:   pick_mode_nxt   = cfg_wdata[vrps_pkg::MODE_BITS-1:0];
        vrps_pkg::REG_SCALAR_MIN:  scalar_min_nxt  = cfg_wdata[vrps_pkg::SCALAR_BITS-1:0];
        vrps_pkg::REG_INDEX_SCALE: index_scale_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (tbl_re) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pick_go) begin
          case (pick_mode_r)
            vrps_pkg::MODE_MAX_INTENSITY: begin
              metric = vrps_pkg::METRIC_BITS'(item_r.scalar);
              take   = !have_best_r || (metric > best_metric_r);
            end
            vrps_pkg::MODE_FIRST_HIT: begin
              metric = vrps_pkg::METRIC_BITS'(rdata_r);
              take   = !first_hit_done_r && (rdata_r != '0);
              if (take) begin
                first_hit_done_nxt = 1'b1;
              end
            end
            vrps_pkg::MODE_MAX_OPACITY: begin
              metric = vrps_pkg::METRIC_BITS'(rdata_r);
              take   = !have_best_r || (metric > best_metric_r);
            end
            vrps_pkg::MODE_MOST_CONTRIB: begin
              metric        = inc;
              take          = !have_best_r || (inc > best_metric_r);
              acc_alpha_nxt = acc_alpha_r + inc[vrps_pkg::ALPHA_BITS-1:0];
            end
            default: ;
          endcase
          if (take) begin
            best_metric_nxt = metric;
            best_index_nxt  = item_r.sample_index;
            have_best_nxt   = 1'b1;
          end
          if (item_r.last_sample) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.hit_found    = have_best_nxt;
            out_data_nxt.picked_index = have_best_nxt ? best_index_nxt : '0;
            // ray done, start the next one clean
            best_metric_nxt    = '0;
            best_index_nxt     = '0;
            have_best_nxt      = 1'b0;
            first_hit_done_nxt = 1'b0;
            acc_alpha_nxt      = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      pick_mode_r      <= vrps_pkg::MODE_MAX_INTENSITY;
      scalar_min_r     <= '0;
      index_scale_r    <= vrps_pkg::INDEX_SCALE_RESET;
      best_metric_r    <= '0;
      best_index_r     <= '0;
      have_best_r      <= 1'b0;
      first_hit_done_r <= 1'b0;
      acc_alpha_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      pick_mode_r      <= pick_mode_nxt;
      scalar_min_r     <= scalar_min_nxt;
      index_scale_r    <= index_scale_nxt;
      best_metric_r    <= best_metric_nxt;
      best_index_r     <= best_index_nxt;
      have_best_r      <= have_best_nxt;
      first_hit_done_r <= first_hit_done_nxt;
      acc_alpha_r      <= acc_alpha_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_re |=> (state_r == ST_PICK))
    else $error("sample item did not enter the pick cycle");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |=> in_ready)
    else $error("table write item held the input side");

  a_result_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PICK))
    else $error("result appeared without a pick cycle");

  a_no_hit_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.hit_found) |-> (out_data_r.picked_index == '0))
    else $error("nonzero picked index without a hit");

endmodule

// ===== bench/ray_pick_checker.sv =====
// ----------------------------------------------------------------------------
// ray_pick_checker
// Watches the sample, result and register ports of the ray pick selector,
// keeps its own copy of the opacity table, the registers and the per-ray pick
// state, and checks every result against the pick it predicts for the ray.
// ----------------------------------------------------------------------------
module ray_pick_checker
  import vrps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  output int                  pending_picks,
  output int                  mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  logic [OPACITY_BITS-1:0] opacity_copy [TABLE_DEPTH];
  logic [MODE_BITS-1:0]    mode_q;
  logic [SCALAR_BITS-1:0]  min_q;
  logic [SCALE_BITS-1:0]   scale_q;

  logic [METRIC_BITS-1:0]  best_metric;
  logic [SAMPLE_BITS-1:0]  best_index;
  logic                    have_best;
  logic                    first_hit_seen;
  logic [ALPHA_BITS-1:0]   alpha_sum;

  out_item_t expected_picks[$];

  initial begin
    pending_picks = 0;
    mismatches = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] pick mismatch: %s", $realtime, what);
    end
    mismatches = mismatches + 1;
  endtask

  function automatic logic [OPACITY_BITS-1:0] opacity_of(input logic [SCALAR_BITS-1:0] s);
    logic [SCALAR_BITS-1:0] diff;
    logic [63:0]            idx;
    diff = (s > min_q) ? s - min_q : '0;
    idx = (64'(diff) * 64'(scale_q)) >> SCALE_FRAC;
    // index past the table end sticks to the last entry
    if (idx > 64'(TABLE_DEPTH - 1)) idx = 64'(TABLE_DEPTH - 1);
    return opacity_copy[idx[TABLE_AW-1:0]];
  endfunction

  task automatic clear_ray();
    best_metric = '0;
    best_index = '0;
    have_best = 1'b0;
    first_hit_seen = 1'b0;
    alpha_sum = '0;
  endtask

  task automatic predict_sample(input in_item_t it);
    logic [OPACITY_BITS-1:0] op;
    logic [METRIC_BITS-1:0]  metric;
    logic [16:0]             alpha_in;
    logic [16:0]             remain;
    logic [33:0]             prod;
    logic                    take;
    out_item_t               pick;
    op = opacity_of(it.scalar);
    metric = '0;
    take = 1'b0;
    case (mode_q)
      MODE_MAX_INTENSITY: begin
        metric = METRIC_BITS'(it.scalar);
        take = !have_best || metric > best_metric;
      end
      MODE_FIRST_HIT: begin
        if (!first_hit_seen && op != '0) begin
          metric = METRIC_BITS'(op);
          take = 1'b1;
          first_hit_seen = 1'b1;
        end
      end
      MODE_MAX_OPACITY: begin
        metric = METRIC_BITS'(op);
        take = !have_best || metric > best_metric;
      end
      default: begin
        // front-to-back alpha increment in q0.16
        alpha_in = 17'(op) * 17'd257;
        remain = 17'h10000 - 17'(alpha_sum);
        prod = 34'(alpha_in) * 34'(remain);
        metric = prod[32:16];
        alpha_sum = alpha_sum + metric[ALPHA_BITS-1:0];
        take = !have_best || metric > best_metric;
      end
    endcase
    if (take) begin
      best_metric = metric;
      best_index = it.sample_index;
      have_best = 1'b1;
    end
    if (it.last_sample) begin
      pick.picked_index = have_best ? best_index : '0;
      pick.hit_found = have_best;
      expected_picks.insert(expected_picks.size(), pick);
      clear_ray();
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mode_q = MODE_MAX_INTENSITY;
      min_q = '0;
      scale_q = INDEX_SCALE_RESET;
      clear_ray();
      expected_picks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PICK_MODE:   mode_q = cfg_wdata[MODE_BITS-1:0];
          REG_SCALAR_MIN:  min_q = cfg_wdata[SCALAR_BITS-1:0];
          REG_INDEX_SCALE: scale_q = cfg_wdata[SCALE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_TABLE_WRITE) begin
          opacity_copy[in_data.table_addr] = in_data.opacity_byte;
        end else begin
          predict_sample(in_data);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("result with no ray pending: index %0d found %0b",
                                    out_data.picked_index, out_data.hit_found));
        end else begin
          want = expected_picks.pop_front();
          if (out_data.picked_index !== want.picked_index) begin
            report_mismatch($sformatf("picked_index %0d, predicted %0d",
                                      out_data.picked_index, want.picked_index));
          end
          if (out_data.hit_found !== want.hit_found) begin
            report_mismatch($sformatf("hit_found %0b, predicted %0b",
                                      out_data.hit_found, want.hit_found));
          end
        end
      end
    end
    pending_picks <= expected_picks.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives opacity table writes, ray samples and register writes into the ray
// pick selector under several idling patterns; ray_pick_checker predicts and
// checks every pick, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vrps_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 25;
  localparam int HOLD_RAYS     = 12;
  localparam int RUN_LIMIT_NS  = 3_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  int pending_picks;
  int mismatches;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int items_sent = 0;
  int table_writes = 0;
  int rays_sent = 0;

  logic [SCALAR_BITS-1:0] cur_min = '0;

  logic [MODE_BITS-1:0] mode_list [4] = '{MODE_MAX_INTENSITY, MODE_FIRST_HIT,
                                          MODE_MAX_OPACITY, MODE_MOST_CONTRIB};

  volume_ray_pick_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ray_pick_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .pending_picks (pending_picks),
    .mismatches    (mismatches)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // result side: random stalls, or a long hold-off each time hold_token moves
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("run limit reached with %0d picks outstanding", pending_picks);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [OPACITY_BITS-1:0] random_opacity();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3:       return '1;
      default: return OPACITY_BITS'($urandom);
    endcase
  endfunction

  function automatic in_item_t write_item(input logic [TABLE_AW-1:0] addr,
                                          input logic [OPACITY_BITS-1:0] opacity);
    in_item_t it;
    it.req_type = REQ_TABLE_WRITE;
    it.table_addr = addr;
    it.opacity_byte = opacity;
    it.scalar = SCALAR_BITS'($urandom);
    it.sample_index = SAMPLE_BITS'($urandom);
    it.last_sample = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t sample_item(input logic [SCALAR_BITS-1:0] s,
                                           input logic [SAMPLE_BITS-1:0] idx,
                                           input logic last);
    in_item_t it;
    it.req_type = REQ_SAMPLE;
    it.table_addr = TABLE_AW'($urandom);
    it.opacity_byte = OPACITY_BITS'($urandom);
    it.scalar = s;
    it.sample_index = idx;
    it.last_sample = last;
    return it;
  endfunction

  function automatic in_item_t random_sample(input logic [SAMPLE_BITS-1:0] idx,
                                             input logic last);
    logic [SCALAR_BITS-1:0] s;
    case ($urandom_range(5))
      0:       s = '0;
      1:       s = '1;
      2:       s = cur_min + SCALAR_BITS'($urandom_range(300));
      3:       s = cur_min - SCALAR_BITS'($urandom_range(40));
      default: s = SCALAR_BITS'($urandom);
    endcase
    return sample_item(s, idx, last);
  endfunction

  function automatic logic [SCALAR_BITS-1:0] random_min();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return SCALAR_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_BITS-1:0] random_scale();
    case ($urandom_range(6))
      0:       return '0;
      1:       return '1;
      2:       return INDEX_SCALE_RESET;
      3:       return 24'h010000;
      4:       return SCALE_BITS'($urandom_range(2048, 1));
      default: return SCALE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
    if (it.req_type == REQ_TABLE_WRITE) table_writes = table_writes + 1;
  endtask

  // stop offering items, wait for every pick, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_picks != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [MODE_BITS-1:0] mode,
                            input logic [SCALAR_BITS-1:0] smin,
                            input logic [SCALE_BITS-1:0] scale);
    cfg_we <= 1'b1;
    cfg_addr <= REG_PICK_MODE;
    cfg_wdata <= CFG_DW'(mode);
    @(posedge clk);
    cfg_addr <= REG_SCALAR_MIN;
    cfg_wdata <= CFG_DW'(smin);
    @(posedge clk);
    cfg_addr <= REG_INDEX_SCALE;
    cfg_wdata <= CFG_DW'(scale);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_min = smin;
  endtask

  task automatic run_ray(input int len);
    logic [SAMPLE_BITS-1:0] pos;
    logic [SAMPLE_BITS-1:0] idx;
    pos = SAMPLE_BITS'($urandom);
    for (int k = 0; k < len; k++) begin
      // table writes in the middle of a ray must not disturb it
      if ($urandom_range(9) == 0) send_item(write_item(TABLE_AW'($urandom), random_opacity()));
      idx = ($urandom_range(4) == 0) ? SAMPLE_BITS'($urandom) : pos + SAMPLE_BITS'(k);
      send_item(random_sample(idx, k == len - 1));
    end
    rays_sent = rays_sent + 1;
  endtask

  initial begin
    int phase_start;
    int len;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table so no sample reads an unwritten entry
    for (int a = 0; a < TABLE_DEPTH; a++) send_item(write_item(TABLE_AW'(a), random_opacity()));
    settle();

    // directed: max intensity with a tie, single-sample ray
    set_config(MODE_MAX_INTENSITY, '0, 24'h010000);
    send_item(write_item(8'd0, 8'd0));
    send_item(write_item(8'd3, 8'd0));
    send_item(write_item(8'd10, 8'd77));
    send_item(write_item(8'd255, 8'd255));
    send_item(sample_item(16'd100, 12'd0, 1'b0));
    send_item(sample_item(16'hFFFF, 12'd1, 1'b0));
    send_item(sample_item(16'hFFFF, 12'd2, 1'b1));
    send_item(sample_item(16'd0, 12'hFFF, 1'b1));
    settle();
    // first hit, then a ray with no hit at all
    set_config(MODE_FIRST_HIT, '0, 24'h010000);
    send_item(sample_item(16'd0, 12'd4, 1'b0));
    send_item(sample_item(16'd10, 12'd5, 1'b0));
    send_item(sample_item(16'd255, 12'd6, 1'b1));
    send_item(sample_item(16'd3, 12'd0, 1'b1));
    settle();
    // scalars below and at the minimum both land on entry zero
    set_config(MODE_MAX_OPACITY, '1, '1);
    send_item(sample_item(16'd0, 12'd7, 1'b0));
    send_item(sample_item(16'hFFFF, 12'd8, 1'b1));
    settle();
    // saturated index, opaque sample then nothing left to contribute
    set_config(MODE_MOST_CONTRIB, '0, '1);
    send_item(sample_item(16'd0, 12'd1, 1'b0));
    send_item(sample_item(16'd1, 12'd2, 1'b0));
    send_item(sample_item(16'd2, 12'd3, 1'b0));
    send_item(sample_item(16'd3, 12'd4, 1'b1));
    // mode change in the middle of a ray
    send_item(sample_item(16'd0, 12'd9, 1'b0));
    settle();
    set_config(MODE_MAX_INTENSITY, '0, 24'h010000);
    send_item(write_item(8'd10, 8'd33));
    send_item(sample_item(16'd7, 12'd10, 1'b0));
    send_item(sample_item(16'd3, 12'd11, 1'b1));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
        default: begin send_idle_pct = 27; recv_stall_pct <= 27; end
      endcase
      set_config(mode_list[ph], random_min(), random_scale());
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(5, 1);
        run_ray(len);
        if ($urandom_range(5) == 0) begin
          settle();
          set_config(mode_list[$urandom_range(3)], random_min(), random_scale());
        end
      end
      settle();
    end

    // long output hold while short rays keep coming, so the input backs up
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    set_config(MODE_MAX_INTENSITY, random_min(), random_scale());
    hold_token <= hold_token + 1;
    for (int r = 0; r < HOLD_RAYS; r++) run_ray($urandom_range(2, 1));
    settle();

    $display("covered %0d items: %0d opacity table writes and %0d rays",
             items_sent, table_writes, rays_sent);
    $display("all pick modes, minimum and scale extremes, four idling mixes, one long stall");
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
